FILE: rtl/gsa_pkg.sv
// Shared types and constants for the generational slot allocator.
`default_nettype none

package gsa_pkg;

  localparam int unsigned IDX_W       = 10;
  localparam int unsigned GEN_W       = 32;
  localparam int unsigned HW_W        = 11;
  localparam int unsigned TABLE_DEPTH = 1024;

  typedef enum logic [1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_FREE    = 2'd1,
    ACT_RESOLVE = 2'd2,
    ACT_NOP     = 2'd3
  } gsa_action_e;

  typedef struct packed {
    gsa_action_e        action;
    logic [IDX_W-1:0]   slot_index;
    logic [GEN_W-1:0]   slot_generation;
  } gsa_req_t;

  typedef struct packed {
    logic [IDX_W-1:0]   handle_index;
    logic [GEN_W-1:0]   handle_generation;
    logic               ok;
  } gsa_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/gsa_ram.sv
// One write port, one registered read port; a read of the address being written returns the new data.
`default_nettype none

module gsa_ram #(
  parameter int unsigned WIDTH  = 33,
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = 10
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= (we_i && (waddr_i == raddr_i)) ? wdata_i : mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/generational_slot_allocator.sv
// Top level of the generational slot allocator: handle table with free list and ABA guard.
`default_nettype none

// Takes one request word per cycle while in_stall_o is low and returns one result word
// per request. A request reads its slot entry and free-list link in the accept cycle,
// is resolved in the following stage, where the generation/live table, link table, free
// head and next never-used index are updated, and lands in the output register. The free
// head and next never-used index seen by an incoming allocate already include the effect
// of the request one stage ahead, so back-to-back requests need no bubbles. After reset a
// clearing pass zeroes the min(SLOTS_PER_PAGE * PAGE_COUNT, 1024) entries of the
// generation/live table, one entry per cycle; no request is taken meanwhile.
module generational_slot_allocator #(
  parameter int unsigned SLOTS_PER_PAGE = 64,
  parameter int unsigned PAGE_COUNT     = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire gsa_pkg::gsa_req_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output gsa_pkg::gsa_rsp_t      out_data_o
);

  import gsa_pkg::*;

  localparam int unsigned RAW_CAP  = SLOTS_PER_PAGE * PAGE_COUNT;
  localparam int unsigned CAPACITY = (RAW_CAP < TABLE_DEPTH) ? RAW_CAP : TABLE_DEPTH;
  localparam int unsigned AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned ENT_W    = GEN_W + 1;
  localparam logic [HW_W-1:0] CAP_HW   = HW_W'(CAPACITY);
  localparam logic [AW-1:0]   CLR_LAST = AW'(CAPACITY - 1);

  // clearing pass
  logic          clr_q, clr_d;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;

  // allocator state
  logic [IDX_W-1:0] head_q, head_d;
  logic [HW_W-1:0]  hw_q, hw_d;

  // resolve stage
  logic             s1_valid_q, s1_valid_d;
  gsa_req_t         s1_req_q;
  logic [IDX_W-1:0] s1_slot_q;
  logic             s1_from_list_q;
  logic             s1_inr_q;

  // output register
  logic     out_valid_q, out_valid_d;
  gsa_rsp_t out_data_q;

  // handshake
  logic s1_adv, s1_fire, accept;

  // stage-1 datapath
  logic [ENT_W-1:0] ent_rd, ent;
  logic [IDX_W-1:0] link_rd;
  logic             live;
  logic [GEN_W-1:0] gen, gen_alloc, gen_inc;
  logic             cur;
  gsa_rsp_t         rsp;
  logic             ent_we, link_we;
  logic [ENT_W-1:0] ent_wdata;

  // accept-side address selection
  logic [IDX_W-1:0] slot_in;
  logic             from_list_in, inr_in;

  // RAM port muxing
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [ENT_W-1:0] ram_wdata;

  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && s1_adv;
  assign in_stall_o = clr_q || (s1_valid_q && !s1_adv);
  assign accept     = in_valid_i && !in_stall_o;

  // ---- stage 1: resolve the request against its slot entry ----
  assign ent     = s1_inr_q ? ent_rd : '0;
  assign live    = ent[GEN_W];
  assign gen     = ent[GEN_W-1:0];
  assign gen_alloc = (gen == '0) ? GEN_W'(1) : gen;
  assign gen_inc = gen + GEN_W'(1);
  assign cur     = (s1_slot_q != '0) && live && (gen == s1_req_q.slot_generation);

  always_comb begin
    head_d    = head_q;
    hw_d      = hw_q;
    ent_we    = 1'b0;
    link_we   = 1'b0;
    ent_wdata = {1'b0, gen};
    rsp.handle_index      = s1_req_q.slot_index;
    rsp.handle_generation = gen;
    rsp.ok                = 1'b0;
    case (s1_req_q.action)
      ACT_ALLOC: begin
        if (s1_slot_q != '0) begin
          ent_we    = 1'b1;
          ent_wdata = {1'b1, gen_alloc};
          if (s1_from_list_q) begin
            head_d = link_rd;
          end else begin
            hw_d = hw_q + HW_W'(1);
          end
          rsp.handle_index      = s1_slot_q;
          rsp.handle_generation = gen_alloc;
          rsp.ok                = 1'b1;
        end else begin
          rsp.handle_index      = '0;
          rsp.handle_generation = '0;
        end
      end
      ACT_FREE: begin
        if (cur) begin
          ent_we    = 1'b1;
          link_we   = 1'b1;
          ent_wdata = {1'b0, gen_inc};
          head_d    = s1_slot_q;
          rsp.handle_generation = gen_inc;
          rsp.ok                = 1'b1;
        end
      end
      ACT_RESOLVE: begin
        rsp.ok = cur;
      end
      default: begin
        rsp.ok = 1'b0;
      end
    endcase
    // only an occupied stage changes state
    if (!s1_valid_q) begin
      head_d  = head_q;
      hw_d    = hw_q;
      ent_we  = 1'b0;
      link_we = 1'b0;
    end
  end

  // ---- accept side: pick the slot using the state after stage 1 ----
  always_comb begin
    from_list_in = 1'b0;
    slot_in      = in_data_i.slot_index;
    if (in_data_i.action == ACT_ALLOC) begin
      if (head_d != '0) begin
        slot_in      = head_d;
        from_list_in = 1'b1;
      end else if (hw_d < CAP_HW) begin
        slot_in = hw_d[IDX_W-1:0];
      end else begin
        slot_in = '0;
      end
    end
    inr_in = ({1'b0, slot_in} < CAP_HW);
  end

  // ---- clearing pass ----
  always_comb begin
    clr_d     = clr_q;
    clr_cnt_d = clr_cnt_q;
    if (clr_q) begin
      clr_cnt_d = clr_cnt_q + AW'(1);
      if (clr_cnt_q == CLR_LAST) begin
        clr_d = 1'b0;
      end
    end
  end

  assign ram_we    = clr_q || (s1_fire && ent_we);
  assign ram_waddr = clr_q ? clr_cnt_q : s1_slot_q[AW-1:0];
  assign ram_wdata = clr_q ? '0 : ent_wdata;

  gsa_ram #(
    .WIDTH  (ENT_W),
    .DEPTH  (CAPACITY),
    .ADDR_W (AW)
  ) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (slot_in[AW-1:0]),
    .rdata_o (ent_rd)
  );

  gsa_ram #(
    .WIDTH  (IDX_W),
    .DEPTH  (CAPACITY),
    .ADDR_W (AW)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (s1_fire && link_we),
    .waddr_i (s1_slot_q[AW-1:0]),
    .wdata_i (head_q),
    .re_i    (accept),
    .raddr_i (slot_in[AW-1:0]),
    .rdata_o (link_rd)
  );

  // ---- control registers ----
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= 1'b1;
      clr_cnt_q   <= '0;
      head_q      <= '0;
      hw_q        <= HW_W'(1);
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      clr_q       <= clr_d;
      clr_cnt_q   <= clr_cnt_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_fire) begin
        head_q <= head_d;
        hw_q   <= hw_d;
      end
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_req_q       <= in_data_i;
      s1_slot_q      <= slot_in;
      s1_from_list_q <= from_list_in;
      s1_inr_q       <= inr_in;
    end
    if (s1_fire) begin
      out_data_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

FILE: bench/tb_generational_slot_allocator.sv
// Self-checking bench for the generational slot allocator: directed and random handle traffic, predicted table.
`default_nettype none

module tb_generational_slot_allocator;
  import gsa_pkg::*;

  localparam int unsigned SLOTS_PER_PAGE = 64;
  localparam int unsigned PAGE_COUNT     = 16;
  localparam int unsigned SLOT_CAP       = (SLOTS_PER_PAGE * PAGE_COUNT < TABLE_DEPTH) ?
                                           SLOTS_PER_PAGE * PAGE_COUNT : TABLE_DEPTH;
  // covers the clearing pass after reset plus the longest receiver stall
  localparam int unsigned STALL_LIMIT    = 5000;

  typedef enum int {MODE_MIX, MODE_FILL, MODE_DRAIN} traffic_mode_e;

  class slot_table_model;
    bit [GEN_W-1:0] gen_tab  [TABLE_DEPTH];
    bit             live_tab [TABLE_DEPTH];
    bit [IDX_W-1:0] link_tab [TABLE_DEPTH];
    bit [IDX_W-1:0] head;
    bit [HW_W-1:0]  next_fresh;
    int unsigned    capacity;
    int unsigned    live_q[$];
    gsa_rsp_t       expected_words[$];
    int unsigned    err_cnt;

    function new(int unsigned cap);
      capacity    = cap;
      head        = '0;
      next_fresh  = 1;
      err_cnt     = 0;
    endfunction

    function void note_request(gsa_req_t req);
      gsa_rsp_t       r;
      bit [IDX_W-1:0] slot;
      bit [IDX_W-1:0] idx;
      bit             current;
      idx = req.slot_index;
      r.handle_index      = idx;
      r.handle_generation = '0;
      r.ok                = 1'b0;
      current = (idx != 0) && live_tab[idx] && (gen_tab[idx] == req.slot_generation);
      case (req.action)
        ACT_ALLOC: begin
          slot = '0;
          if (head != 0) begin
            slot = head;
            head = link_tab[slot];
          end else if (next_fresh < capacity) begin
            slot = next_fresh[IDX_W-1:0];
            next_fresh = next_fresh + 1'b1;
          end
          if (slot != 0) begin
            if (gen_tab[slot] == 0) gen_tab[slot] = 1;
            live_tab[slot]      = 1'b1;
            r.handle_index      = slot;
            r.handle_generation = gen_tab[slot];
            r.ok                = 1'b1;
            live_q.push_back(slot);
          end else begin
            r.handle_index = '0;
          end
        end
        ACT_FREE: begin
          if (current) begin
            gen_tab[idx]  = gen_tab[idx] + 1;
            live_tab[idx] = 1'b0;
            link_tab[idx] = head;
            head          = idx;
            r.ok          = 1'b1;
            for (int k = 0; k < live_q.size(); k++) begin
              if (live_q[k] == idx) begin
                live_q.delete(k);
                break;
              end
            end
          end
          r.handle_generation = gen_tab[idx];
        end
        ACT_RESOLVE: begin
          r.ok                = current;
          r.handle_generation = gen_tab[idx];
        end
        default: begin
          r.handle_generation = gen_tab[idx];
        end
      endcase
      expected_words.push_back(r);
    endfunction

    function void check_result(gsa_rsp_t rsp);
      gsa_rsp_t want;
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected: index %0d gen %0h ok %0b",
               rsp.handle_index, rsp.handle_generation, rsp.ok);
        err_cnt++;
        return;
      end
      want = expected_words.pop_front();
      if (rsp.handle_index !== want.handle_index) begin
        $error("handle_index expected %0d got %0d", want.handle_index, rsp.handle_index);
        err_cnt++;
      end
      if (rsp.handle_generation !== want.handle_generation) begin
        $error("handle_generation expected %0h got %0h",
               want.handle_generation, rsp.handle_generation);
        err_cnt++;
      end
      if (rsp.ok !== want.ok) begin
        $error("ok expected %0b got %0b", want.ok, rsp.ok);
        err_cnt++;
      end
    endfunction
  endclass

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall_o;
  gsa_req_t in_data = '0;
  logic     out_valid_o;
  logic     out_stall = 1'b0;
  gsa_rsp_t out_data_o;

  slot_table_model slots;
  int unsigned     burst_left = 0;
  int unsigned     quiet_cycles = 0;
  bit [15:0]       stall_pat = '0;
  bit [5:0]        stall_step = '0;

  generational_slot_allocator #(
    .SLOTS_PER_PAGE(SLOTS_PER_PAGE),
    .PAGE_COUNT    (PAGE_COUNT)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_data_o (out_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // receiver: a 16-bit stall pattern, redrawn whenever the 6-bit step counter wraps; bit 0 never stalls
  always @(negedge clk_i) begin
    if (stall_step == 0) begin
      case ($urandom_range(3))
        0:       stall_pat = '0;
        1:       stall_pat = 16'($urandom) & 16'($urandom);
        2:       stall_pat = 16'($urandom);
        default: stall_pat = 16'($urandom) | 16'($urandom);
      endcase
      stall_pat[0] = 1'b0;
    end
    out_stall <= stall_pat[stall_step[3:0]];
    stall_step = stall_step + 1'b1;
  end

  always @(posedge clk_i) begin
    if (in_valid === 1'b1 && in_stall_o === 1'b0) slots.note_request(in_data);
    if (out_valid_o === 1'b1 && out_stall === 1'b0) slots.check_result(out_data_o);
    if ((in_valid === 1'b1 && in_stall_o === 1'b0) ||
        (out_valid_o === 1'b1 && out_stall === 1'b0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL generational_slot_allocator");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic gsa_req_t req_of(gsa_action_e act, int unsigned idx, logic [GEN_W-1:0] g);
    gsa_req_t req;
    req.action          = act;
    req.slot_index      = IDX_W'(idx);
    req.slot_generation = g;
    return req;
  endfunction

  function automatic gsa_req_t make_request(traffic_mode_e mode);
    gsa_req_t    req;
    int unsigned roll;
    int unsigned idx;
    int unsigned a_lim;
    int unsigned f_lim;
    int unsigned r_lim;
    int unsigned s_lim;
    req.action          = ACT_ALLOC;
    req.slot_index      = IDX_W'($urandom);
    req.slot_generation = $urandom;
    case (mode)
      MODE_FILL:  begin a_lim = 85; f_lim = 85; r_lim = 92; s_lim = 95; end
      MODE_DRAIN: begin a_lim = 10; f_lim = 65; r_lim = 78; s_lim = 88; end
      default:    begin a_lim = 35; f_lim = 60; r_lim = 75; s_lim = 85; end
    endcase
    roll = $urandom_range(99);
    if (roll < a_lim) begin
      req.action = ACT_ALLOC;
    end else if (roll < r_lim && slots.live_q.size() != 0) begin
      idx = slots.live_q[$urandom_range(slots.live_q.size() - 1)];
      req.action          = (roll < f_lim) ? ACT_FREE : ACT_RESOLVE;
      req.slot_index      = IDX_W'(idx);
      req.slot_generation = slots.gen_tab[idx];
    end else if (roll < s_lim && slots.next_fresh > 1) begin
      // current or one-behind generation on a slot that may be live or already dead
      idx = $urandom_range(1, slots.next_fresh - 1);
      req.action          = $urandom_range(1) ? ACT_FREE : ACT_RESOLVE;
      req.slot_index      = IDX_W'(idx);
      req.slot_generation = slots.gen_tab[idx] - $urandom_range(1);
    end else begin
      req.action = gsa_action_e'($urandom_range(3));
      if ($urandom_range(3) == 0) req.slot_index = '0;
    end
    return req;
  endfunction

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_word(input gsa_req_t req);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    in_data  <= req;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (slots.expected_words.size() != 0) @(negedge clk_i);
    burst_left = 0;
  endtask

  task automatic run_traffic(traffic_mode_e mode, int unsigned count);
    repeat (count) send_word(make_request(mode));
    wait_drained();
  endtask

  initial begin
    gsa_req_t    directed[$];
    slots = new(SLOT_CAP);
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    directed.push_back(req_of(ACT_RESOLVE, 0, '0));             // null handle
    directed.push_back(req_of(ACT_FREE, 0, '0));
    directed.push_back(req_of(ACT_RESOLVE, 1023, '0));          // never allocated
    directed.push_back(req_of(ACT_NOP, 1023, 32'hFFFF_FFFF));
    directed.push_back(req_of(ACT_ALLOC, 1023, 32'hFFFF_FFFF));
    directed.push_back(req_of(ACT_ALLOC, 0, '0));
    directed.push_back(req_of(ACT_ALLOC, 512, 32'h5555_5555));
    directed.push_back(req_of(ACT_RESOLVE, 1, 32'd1));
    directed.push_back(req_of(ACT_RESOLVE, 1, 32'd0));
    directed.push_back(req_of(ACT_RESOLVE, 1, 32'hFFFF_FFFF));
    directed.push_back(req_of(ACT_FREE, 2, 32'd2));             // generation that does not match
    directed.push_back(req_of(ACT_FREE, 2, 32'd1));
    directed.push_back(req_of(ACT_FREE, 2, 32'd1));             // already dead
    directed.push_back(req_of(ACT_RESOLVE, 2, 32'd1));
    directed.push_back(req_of(ACT_RESOLVE, 2, 32'd2));
    directed.push_back(req_of(ACT_ALLOC, 0, '0));               // reuses slot 2
    directed.push_back(req_of(ACT_FREE, 1, 32'd1));
    directed.push_back(req_of(ACT_FREE, 3, 32'd1));
    directed.push_back(req_of(ACT_ALLOC, 0, '0));
    directed.push_back(req_of(ACT_ALLOC, 0, '0));
    directed.push_back(req_of(ACT_ALLOC, 0, '0));
    directed.push_back(req_of(ACT_NOP, 2, '0));
    directed.push_back(req_of(ACT_FREE, 0, 32'hFFFF_FFFF));
    foreach (directed[k]) send_word(directed[k]);
    wait_drained();

    run_traffic(MODE_MIX, 200);
    // allocation-heavy phase to build up a well-populated table
    run_traffic(MODE_FILL, 250);
    run_traffic(MODE_DRAIN, 150);
    run_traffic(MODE_MIX, 180);

    repeat (10) @(negedge clk_i);
    if (slots.expected_words.size() != 0) begin
      $error("%0d result words never arrived", slots.expected_words.size());
      slots.err_cnt++;
    end
    if (slots.err_cnt == 0) begin
      $display("PASS generational_slot_allocator");
    end else begin
      $display("FAIL generational_slot_allocator");
    end
    $finish;
  end

endmodule

`default_nettype wire
